@@ hw/rtl/act_pkg.sv @@
package act_pkg;

	typedef enum logic [3:0] {
		TK_NEWLINE      = 4'd0,
		TK_COMMA        = 4'd1,
		TK_REGISTER     = 4'd2,
		TK_ADDRESS      = 4'd3,
		TK_LABEL        = 4'd4,
		TK_MNEMONIC     = 4'd5,
		TK_BAD_MNEMONIC = 4'd6,
		TK_BAD_SYMBOL   = 4'd7,
		TK_BAD_REG_NUM  = 4'd8,
		TK_REG_LETTER   = 4'd9,
		TK_ADDR_LARGE   = 4'd10,
		TK_ADDR_LETTER  = 4'd11,
		TK_DONE         = 4'd12
	} token_kind_t;

	typedef struct packed {
		logic [15:0] line;
		logic [7:0]  label_length;
		logic [9:0]  number;
		logic [3:0]  opcode;
		token_kind_t kind;
	} token_t;

	localparam int TOKEN_BITS = $bits(token_t);
	localparam int TDATA_OUT_BITS = ((TOKEN_BITS + 7) / 8) * 8;

	localparam logic [1:0] CFG_LINE_START     = 2'd0;
	localparam logic [1:0] CFG_ADDRESS_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_REGISTER_LIMIT = 2'd2;

	localparam logic [3:0] NO_OP = 4'd15;
	localparam int         MNEM_COUNT = 15;

	localparam logic [31:0] MNEM_NAME [MNEM_COUNT] = '{
		"HALT", "ADD", "SUB", "AND", "XOR", "NOT", "JMP", "CMP",
		"MOV", "ASL", "ASR", "LSL", "LSR", "LOAD", "SAVE"
	};

	localparam logic [2:0] MNEM_LEN [MNEM_COUNT] = '{
		3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
	};

	function automatic logic [3:0] find_opcode(input logic [31:0] name,
			input logic [2:0] len);
		logic [3:0] op;
		op = NO_OP;
		for (int i = 0; i < MNEM_COUNT; i++) begin
			if (MNEM_LEN[i] == len && MNEM_NAME[i] == name) begin
				op = 4'(i);
			end
		end
		return op;
	endfunction

endpackage

@@ hw/rtl/assembly_char_tokenizer_core.sv @@
// Assembly character tokenizer. Each input transaction carries one source character in
// s_axis_tdata, with s_axis_tlast set on the last character of the source. Each output
// transaction carries one token; m_axis_tlast marks the last token caused by a character.
// A character's tokens (zero to three) go into a three-entry result buffer that drains one
// token per cycle while m_axis_tready is high, so the block runs at one character per cycle
// while each character yields at most one token and the result side stays ready, and a
// character that yields two or three tokens holds off the next character until only one of
// its tokens is left in the buffer. The configuration channel is always ready; writing
// line_start also reloads the line counter.
module assembly_char_tokenizer_core #(
	parameter int LINE_BITS   = 16,
	parameter int NUMBER_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // char_in
	input  logic                                s_axis_tlast,  // end_of_file
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// token_kind[3:0], opcode[7:4], number[17:8], label_length[25:18], line[41:26]
	output logic [act_pkg::TDATA_OUT_BITS-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast,  // last_of_run
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [15:0]                         cfg_data
);

	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_REG   = 5'b00010,
		MODE_ADDR  = 5'b00100,
		MODE_OP    = 5'b01000,
		MODE_LABEL = 5'b10000
	} lex_mode_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_R       = 8'h52;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;

	logic [9:0]             address_limit_q;
	logic [3:0]             register_limit_q;

	lex_mode_t              mode_q, mode_d;
	logic [31:0]            mbuf_q, mbuf_d;
	logic [2:0]             mcnt_q, mcnt_d;
	logic [NUMBER_BITS-1:0] acc_q, acc_d;
	logic                   digit_seen_q, digit_seen_d;
	logic                   letter_err_q, letter_err_d;
	logic [7:0]             label_cnt_q, label_cnt_d;
	logic [LINE_BITS-1:0]   line_q, line_d;

	act_pkg::token_t        out_q [3];
	logic [2:0]             last_q;
	logic [1:0]             cnt_q;

	act_pkg::token_t        cand [3];
	logic [2:0]             cand_v;
	act_pkg::token_t        new_tok [3];
	logic [2:0]             new_last;
	logic [1:0]             new_n;

	logic                   s_fire, m_fire, cfg_fire;
	logic [7:0]             c;
	logic                   eof, is_dig, is_alp, is_spc, redo;
	logic [3:0]             digit;
	logic [3:0]             op;

	function automatic logic [NUMBER_BITS-1:0] acc_digit(input logic [NUMBER_BITS-1:0] a,
			input logic [3:0] d);
		logic [NUMBER_BITS+3:0] v;
		v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + (NUMBER_BITS+4)'(d);
		if (v > (NUMBER_BITS+4)'({NUMBER_BITS{1'b1}})) begin
			return '1;
		end
		return v[NUMBER_BITS-1:0];
	endfunction

	function automatic logic [9:0] sat_number(input logic [NUMBER_BITS-1:0] a);
		if (a > NUMBER_BITS'(10'h3FF)) begin
			return 10'h3FF;
		end
		return a[9:0];
	endfunction

	function automatic act_pkg::token_t make_token(input act_pkg::token_kind_t kind,
			input logic [3:0] opc, input logic [9:0] num, input logic [7:0] lab,
			input logic [LINE_BITS-1:0] ln);
		act_pkg::token_t t;
		t.kind         = kind;
		t.opcode       = opc;
		t.number       = num;
		t.label_length = lab;
		t.line         = 16'(ln);
		return t;
	endfunction

	assign c      = s_axis_tdata;
	assign eof    = s_axis_tlast;
	assign is_dig = (c >= 8'h30) && (c <= 8'h39);
	assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	assign is_spc = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	assign digit  = 4'(c - CH_ZERO);
	assign op     = act_pkg::find_opcode(mbuf_q, mcnt_q);

	assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_fire        = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = act_pkg::TDATA_OUT_BITS'(out_q[0]);
	assign m_axis_tlast  = last_q[0];
	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;

	always_comb begin
		mode_d       = mode_q;
		mbuf_d       = mbuf_q;
		mcnt_d       = mcnt_q;
		acc_d        = acc_q;
		digit_seen_d = digit_seen_q;
		letter_err_d = letter_err_q;
		label_cnt_d  = label_cnt_q;
		line_d       = line_q;
		cand_v       = '0;
		redo         = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cand[i] = '0;
		end

		unique case (mode_q)
			MODE_REG: begin
				if (is_dig) begin
					acc_d        = acc_digit(acc_q, digit);
					digit_seen_d = 1'b1;
				end else if (is_alp) begin
					letter_err_d = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					priority if (letter_err_q) begin
						cand[0] = make_token(act_pkg::TK_REG_LETTER, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end else if (!digit_seen_q ||
							acc_q > NUMBER_BITS'(register_limit_q)) begin
						cand[0] = make_token(act_pkg::TK_BAD_REG_NUM, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end else begin
						cand[0] = make_token(act_pkg::TK_REGISTER, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end
					mode_d = MODE_IDLE;
					redo   = 1'b1;
				end
			end
			MODE_ADDR: begin
				if (is_dig) begin
					if (!letter_err_q) begin
						acc_d = acc_digit(acc_q, digit);
					end
				end else if (is_alp) begin
					letter_err_d = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					priority if (acc_q > NUMBER_BITS'(address_limit_q)) begin
						cand[0] = make_token(act_pkg::TK_ADDR_LARGE, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end else if (letter_err_q) begin
						cand[0] = make_token(act_pkg::TK_ADDR_LETTER, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end else begin
						cand[0] = make_token(act_pkg::TK_ADDRESS, act_pkg::NO_OP,
							sat_number(acc_q), 8'd0, line_q);
					end
					mode_d = MODE_IDLE;
					redo   = 1'b1;
				end
			end
			MODE_OP: begin
				if (is_dig || is_alp) begin
					if (mcnt_q < 3'd4) begin
						mbuf_d = {mbuf_q[23:0], c};
						mcnt_d = mcnt_q + 3'd1;
					end else begin
						mcnt_d = 3'd5;
					end
				end else begin
					cand_v[0] = 1'b1;
					cand[0] = make_token((op == act_pkg::NO_OP) ? act_pkg::TK_BAD_MNEMONIC :
						act_pkg::TK_MNEMONIC, op, 10'd0, 8'd0, line_q);
					mode_d = MODE_IDLE;
					redo   = 1'b1;
				end
			end
			MODE_LABEL: begin
				if (is_dig || is_alp) begin
					if (label_cnt_q != 8'hFF) begin
						label_cnt_d = label_cnt_q + 8'd1;
					end
				end else begin
					cand_v[0] = 1'b1;
					cand[0] = make_token(act_pkg::TK_LABEL, act_pkg::NO_OP, 10'd0,
						label_cnt_q, line_q);
					mode_d = MODE_IDLE;
					if (!eof) begin
						line_d = line_q - LINE_BITS'(1);
						redo   = 1'b1;
					end
				end
			end
			default: begin
				redo = 1'b1;
			end
		endcase

		if (redo) begin
			mode_d = MODE_IDLE;
			priority if (c == CH_NEWLINE) begin
				cand_v[1] = 1'b1;
				cand[1] = make_token(act_pkg::TK_NEWLINE, act_pkg::NO_OP, 10'd0, 8'd0,
					line_d);
				line_d = line_d + LINE_BITS'(1);
			end else if (is_spc) begin
				mode_d = MODE_IDLE;
			end else if (is_alp && c != CH_R) begin
				mode_d = MODE_OP;
				mbuf_d = {24'd0, c};
				mcnt_d = 3'd1;
			end else if (c == CH_R) begin
				mode_d       = MODE_REG;
				acc_d        = '0;
				digit_seen_d = 1'b0;
				letter_err_d = 1'b0;
			end else if (is_dig) begin
				mode_d       = MODE_ADDR;
				acc_d        = NUMBER_BITS'(digit);
				letter_err_d = 1'b0;
			end else if (c == CH_COMMA) begin
				cand_v[1] = 1'b1;
				cand[1] = make_token(act_pkg::TK_COMMA, act_pkg::NO_OP, 10'd0, 8'd0, line_d);
			end else if (c == CH_DOT) begin
				mode_d      = MODE_LABEL;
				label_cnt_d = 8'd1;
			end else begin
				cand_v[1] = 1'b1;
				cand[1] = make_token(act_pkg::TK_BAD_SYMBOL, act_pkg::NO_OP, 10'd0, 8'd0,
					line_d);
			end
		end

		if (eof) begin
			mode_d       = MODE_IDLE;
			mbuf_d       = '0;
			mcnt_d       = '0;
			acc_d        = '0;
			digit_seen_d = 1'b0;
			letter_err_d = 1'b0;
			label_cnt_d  = '0;
			cand_v[2]    = 1'b1;
			cand[2] = make_token(act_pkg::TK_DONE, act_pkg::NO_OP, 10'd0, 8'd0, line_d);
		end
	end

	always_comb begin
		new_n    = '0;
		new_last = '0;
		for (int i = 0; i < 3; i++) begin
			new_tok[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			if (cand_v[i]) begin
				new_tok[new_n] = cand[i];
				new_n = new_n + 2'd1;
			end
		end
		if (new_n != 2'd0) begin
			new_last[new_n - 2'd1] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_limit_q  <= 10'd512;
			register_limit_q <= 4'd7;
			mode_q           <= MODE_IDLE;
			mbuf_q           <= '0;
			mcnt_q           <= '0;
			acc_q            <= '0;
			digit_seen_q     <= 1'b0;
			letter_err_q     <= 1'b0;
			label_cnt_q      <= '0;
			line_q           <= LINE_BITS'(1);
			cnt_q            <= '0;
		end else begin
			if (s_fire) begin
				mode_q       <= mode_d;
				mbuf_q       <= mbuf_d;
				mcnt_q       <= mcnt_d;
				acc_q        <= acc_d;
				digit_seen_q <= digit_seen_d;
				letter_err_q <= letter_err_d;
				label_cnt_q  <= label_cnt_d;
				cnt_q        <= new_n;
			end else if (m_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (cfg_fire && (cfg_index == act_pkg::CFG_LINE_START)) begin
				line_q <= LINE_BITS'(cfg_data);
			end else if (s_fire) begin
				line_q <= line_d;
			end
			if (cfg_fire && (cfg_index == act_pkg::CFG_ADDRESS_LIMIT)) begin
				address_limit_q <= cfg_data[9:0];
			end
			if (cfg_fire && (cfg_index == act_pkg::CFG_REGISTER_LIMIT)) begin
				register_limit_q <= cfg_data[3:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_q  <= new_tok;
			last_q <= new_last;
		end else if (m_fire) begin
			out_q[0]  <= out_q[1];
			out_q[1]  <= out_q[2];
			last_q[0] <= last_q[1];
			last_q[1] <= last_q[2];
		end
	end

endmodule
